// ===== src/amcp_pkg.sv =====
// ----------------------------------------------------------------------------
// amcp_pkg
// Shared codes, character constants and result layout for the ASCII motion
// command parser.
// ----------------------------------------------------------------------------
package amcp_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DIR_W    = 3;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned NUM_DIRS = 4;
  localparam int unsigned NUM_VALS = 2;

  localparam logic [DIR_W-1:0] MAX_SENSOR_DIRECTIONS = 3'd4;
  localparam logic [DIR_W-1:0] MAX_MOTOR_DIRECTIONS  = 3'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD    = 2'd1;
  localparam logic [1:0] ST_NODASH = 2'd2;

  localparam logic [DIR_W-1:0] DIR_NONE     = 3'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT    = 3'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT     = 3'd2;
  localparam logic [DIR_W-1:0] DIR_FORWARD  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_BACKWARD = 3'd4;

  localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
  localparam logic [CHAR_W-1:0] CH_DASH = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_S    = 8'h53;
  localparam logic [CHAR_W-1:0] CH_G    = 8'h47;
  localparam logic [CHAR_W-1:0] CH_V    = 8'h56;
  localparam logic [CHAR_W-1:0] CH_R    = 8'h52;
  localparam logic [CHAR_W-1:0] CH_L    = 8'h4C;
  localparam logic [CHAR_W-1:0] CH_F    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_B    = 8'h42;

  // Packed so that the last field, status, lands in the lowest bits.
  typedef struct packed {
    logic [VALUE_W-1:0] value_1;
    logic [VALUE_W-1:0] value_0;
    logic [DIR_W-1:0]   dir_count;
    logic [DIR_W-1:0]   dir_3;
    logic [DIR_W-1:0]   dir_2;
    logic [DIR_W-1:0]   dir_1;
    logic [DIR_W-1:0]   dir_0;
    logic               target_is_velocity;
    logic               op_is_get;
    logic [1:0]         status;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned OUT_W    = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== src/ascii_motion_command_parser_unit.sv =====
// ----------------------------------------------------------------------------
// ascii_motion_command_parser_unit
// Parses ASCII motion commands, one character per input item, and emits one
// decoded result item for every NUL.
//
// Input channel s_axis: one character per item in tdata[7:0].
// Output channel m_axis: one result item per NUL character.
// Throughput: one character per cycle while s_axis_tready is high; the state
// machine step for an item is combinational logic ahead of the command registers.
// The result is registered and appears on m_axis in the cycle after its NUL is accepted.
// Other characters produce no output item.
// The output register holds a result while m_axis_tready is low; input is
// held off for any character meanwhile, so s_axis_tready is low exactly
// while a result waits and m_axis_tready is low.
// Reset clears the command state to expect a type letter and empties the
// output register.
// ----------------------------------------------------------------------------
module ascii_motion_command_parser_unit import amcp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [CHAR_W-1:0] s_axis_tdata,   // [7:0] char_in
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [1:0] status, [2] op_is_get, [3] target_is_velocity, [6:4] dir_0,
  // [9:7] dir_1, [12:10] dir_2, [15:13] dir_3, [18:16] dir_count,
  // [34:19] value_0, [50:35] value_1, [55:51] zero
  output logic [OUT_W-1:0]  m_axis_tdata
);

  logic    s_fire;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  amcp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (s_fire),
    .char_in   (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {{(OUT_W - RESULT_W){1'b0}}, out_res};

  a_nul_gives_item: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_axis_tdata == CH_NUL |=> m_axis_tvalid)
    else $error("NUL accepted without a result item");

  a_char_no_item: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_axis_tdata != CH_NUL && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result item without a NUL");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_res.status != ST_OK |-> m_axis_tdata[RESULT_W-1:2] == '0)
    else $error("error result with nonzero fields");

  a_get_no_values: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_res.op_is_get |-> out_res.value_0 == '0 && out_res.value_1 == '0)
    else $error("get result carries values");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_res.dir_count <= MAX_SENSOR_DIRECTIONS)
    else $error("direction count out of range");

endmodule

// ===== src/amcp_core.sv =====
// ----------------------------------------------------------------------------
// amcp_core
// Command state machine: consumes one character per accepted item and
// produces a result on every NUL.
// ----------------------------------------------------------------------------
module amcp_core import amcp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [CHAR_W-1:0] char_in,
  output logic              res_valid,
  output result_t           res
);

  typedef enum logic [2:0] {
    PH_TYPE, PH_TARGET, PH_GETDIRS, PH_SETDIRS, PH_HEX, PH_END, PH_IGNORE, PH_SKIP
  } phase_t;

  phase_t             phase, phase_next;
  logic [3:0]         position, position_next;
  logic               get_flag, get_flag_next;
  logic               velocity_flag, velocity_flag_next;
  logic [DIR_W-1:0]   dirs [NUM_DIRS];
  logic [DIR_W-1:0]   dirs_next [NUM_DIRS];
  logic [DIR_W-1:0]   total, total_next;
  logic [VALUE_W-1:0] words [NUM_VALS];
  logic [VALUE_W-1:0] words_next [NUM_VALS];
  logic [1:0]         err, err_next;

  logic [CHAR_W-1:0]  up;
  logic [DIR_W-1:0]   dcode;
  logic               hex_ok;
  logic [3:0]         hex_val;
  logic [3:0]         pos_inc;
  logic [DIR_W-1:0]   total_inc;
  logic [DIR_W-1:0]   get_limit;
  logic [1:0]         status;

  always_comb begin
    up = char_in;
    if (char_in >= 8'h61 && char_in <= 8'h7A) begin
      up = char_in - 8'd32;
    end
    case (up)
      CH_R:    dcode = DIR_RIGHT;
      CH_L:    dcode = DIR_LEFT;
      CH_F:    dcode = DIR_FORWARD;
      CH_B:    dcode = DIR_BACKWARD;
      default: dcode = DIR_NONE;
    endcase
    hex_ok  = 1'b0;
    hex_val = char_in[3:0];
    if (char_in >= 8'h30 && char_in <= 8'h39) begin
      hex_ok = 1'b1;
    end else if (up >= 8'h41 && up <= 8'h46) begin
      hex_ok  = 1'b1;
      hex_val = up[3:0] + 4'd9;
    end
  end

  assign pos_inc   = position + 4'd1;
  assign total_inc = total + 3'd1;
  assign get_limit = velocity_flag ? MAX_MOTOR_DIRECTIONS : MAX_SENSOR_DIRECTIONS;

  always_comb begin
    phase_next         = phase;
    position_next      = position;
    get_flag_next      = get_flag;
    velocity_flag_next = velocity_flag;
    dirs_next          = dirs;
    total_next         = total;
    words_next         = words;
    err_next           = err;
    status             = ST_BAD;
    res_valid          = 1'b0;

    if (char_in == CH_NUL) begin
      res_valid = fire;
      unique case (phase)
        PH_GETDIRS, PH_END, PH_IGNORE: status = ST_OK;
        PH_SKIP:    status = err;
        PH_SETDIRS: status = (total >= MAX_MOTOR_DIRECTIONS) ? ST_NODASH : ST_BAD;
        default:    status = ST_BAD;
      endcase
      phase_next         = PH_TYPE;
      position_next      = '0;
      get_flag_next      = 1'b0;
      velocity_flag_next = 1'b0;
      for (int i = 0; i < NUM_DIRS; i++) dirs_next[i] = DIR_NONE;
      total_next         = '0;
      for (int i = 0; i < NUM_VALS; i++) words_next[i] = '0;
      err_next           = ST_OK;
    end else begin
      unique case (phase)
        PH_TYPE: begin
          if (up == CH_S) begin
            get_flag_next = 1'b0;
            phase_next    = PH_TARGET;
          end else if (up == CH_G) begin
            get_flag_next = 1'b1;
            phase_next    = PH_TARGET;
          end else begin
            err_next   = ST_BAD;
            phase_next = PH_SKIP;
          end
        end
        PH_TARGET: begin
          if (up == CH_S) begin
            velocity_flag_next = 1'b0;
            if (!get_flag) begin
              err_next   = ST_BAD;
              phase_next = PH_SKIP;
            end else begin
              phase_next = PH_GETDIRS;
            end
          end else if (up == CH_V) begin
            velocity_flag_next = 1'b1;
            phase_next         = get_flag ? PH_GETDIRS : PH_SETDIRS;
          end else begin
            err_next   = ST_BAD;
            phase_next = PH_SKIP;
          end
        end
        PH_GETDIRS: begin
          if (dcode == DIR_NONE ||
              (velocity_flag && dcode != DIR_RIGHT && dcode != DIR_LEFT)) begin
            err_next   = ST_BAD;
            phase_next = PH_SKIP;
          end else begin
            if (!total[2]) dirs_next[total[1:0]] = dcode;
            total_next = total_inc;
            if (total_inc >= get_limit) phase_next = PH_IGNORE;
          end
        end
        PH_SETDIRS: begin
          if (char_in == CH_DASH) begin
            position_next = '0;
            phase_next    = (total == '0) ? PH_END : PH_HEX;
          end else if (total >= MAX_MOTOR_DIRECTIONS) begin
            err_next   = ST_NODASH;
            phase_next = PH_SKIP;
          end else if (dcode != DIR_RIGHT && dcode != DIR_LEFT) begin
            err_next   = ST_BAD;
            phase_next = PH_SKIP;
          end else begin
            if (!total[2]) dirs_next[total[1:0]] = dcode;
            total_next = total_inc;
          end
        end
        PH_HEX: begin
          if (!hex_ok) begin
            err_next   = ST_BAD;
            phase_next = PH_SKIP;
          end else begin
            words_next[position[2]] = {words[position[2]][VALUE_W-5:0], hex_val};
            position_next = pos_inc;
            if ({1'b0, pos_inc} >= {total, 2'b00} || pos_inc[3]) phase_next = PH_END;
          end
        end
        PH_END: begin
          err_next   = ST_BAD;
          phase_next = PH_SKIP;
        end
        PH_IGNORE: ;
        PH_SKIP:   ;
      endcase
    end
  end

  always_comb begin
    res        = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.op_is_get          = get_flag;
      res.target_is_velocity = velocity_flag;
      res.dir_0              = dirs[0];
      res.dir_1              = dirs[1];
      res.dir_2              = dirs[2];
      res.dir_3              = dirs[3];
      res.dir_count          = total;
      if (!get_flag) begin
        res.value_0 = words[0];
        res.value_1 = words[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TYPE;
      position      <= '0;
      get_flag      <= 1'b0;
      velocity_flag <= 1'b0;
      for (int i = 0; i < NUM_DIRS; i++) dirs[i] <= DIR_NONE;
      total         <= '0;
      for (int i = 0; i < NUM_VALS; i++) words[i] <= '0;
      err           <= ST_OK;
    end else if (fire) begin
      phase         <= phase_next;
      position      <= position_next;
      get_flag      <= get_flag_next;
      velocity_flag <= velocity_flag_next;
      dirs          <= dirs_next;
      total         <= total_next;
      words         <= words_next;
      err           <= err_next;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ASCII motion command parser. Commands go in one
// character per item, directed cases first, then random well-formed, broken
// and noise commands under sender bursts and receiver stalls. Each result item
// is checked field by field against a local command decoder.
// ----------------------------------------------------------------------------
module testbench;
  import amcp_pkg::*;

  localparam int unsigned RANDOM_CHARS = 1800;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned IDLE_LIMIT   = 1000;

  localparam logic [CHAR_W-1:0] DIR_LETTERS [4] = '{CH_R, CH_L, CH_F, CH_B};

  typedef enum logic [2:0] {
    AWAIT_TYPE, AWAIT_TARGET, GET_DIRS, SET_DIRS,
    HEX_DIGITS, AWAIT_NUL, IGNORE_REST, SKIP_TO_NUL
  } cmd_phase_e;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_valid = 1'b0;
  logic [CHAR_W-1:0] s_data = '0;
  logic              m_ready = 1'b0;
  logic              s_axis_tready;
  logic              m_axis_tvalid;
  logic [OUT_W-1:0]  m_axis_tdata;

  cmd_phase_e        cmd_phase;
  logic [3:0]        hex_pos;
  logic              cmd_get;
  logic              cmd_vel;
  logic [DIR_W-1:0]  cmd_dirs [NUM_DIRS];
  logic [DIR_W-1:0]  cmd_ndirs;
  logic [VALUE_W-1:0] cmd_words [NUM_VALS];
  logic [1:0]        cmd_err;

  result_t           pending_results [$];
  logic [CHAR_W-1:0] cmd_buf [$];

  int unsigned       mismatches = 0;
  int unsigned       chars_sent = 0;
  int unsigned       burst_left = 0;
  bit                tx_idle_en = 1'b0;
  rx_mode_e          rx_mode = RX_ALWAYS;
  int unsigned       hold_seq = 0;

  always #5 clk = ~clk;

  ascii_motion_command_parser_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic logic [CHAR_W-1:0] upcase(logic [CHAR_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
  endfunction

  function automatic logic [DIR_W-1:0] dir_code(logic [CHAR_W-1:0] c);
    case (upcase(c))
      CH_R: return DIR_RIGHT;
      CH_L: return DIR_LEFT;
      CH_F: return DIR_FORWARD;
      CH_B: return DIR_BACKWARD;
      default: return DIR_NONE;
    endcase
  endfunction

  function automatic void reset_cmd();
    cmd_phase = AWAIT_TYPE;
    hex_pos   = '0;
    cmd_get   = 1'b0;
    cmd_vel   = 1'b0;
    foreach (cmd_dirs[k]) cmd_dirs[k] = DIR_NONE;
    cmd_ndirs = '0;
    foreach (cmd_words[k]) cmd_words[k] = '0;
    cmd_err   = ST_OK;
  endfunction

  function automatic void fail_cmd(logic [1:0] code);
    cmd_err   = code;
    cmd_phase = SKIP_TO_NUL;
  endfunction

  function automatic void push_dir(logic [DIR_W-1:0] d);
    if (cmd_ndirs < NUM_DIRS) cmd_dirs[cmd_ndirs] = d;
    cmd_ndirs = cmd_ndirs + 1'b1;
  endfunction

  function automatic void finish_cmd(logic [1:0] st);
    result_t r;
    r = '0;
    r.status = st;
    if (st == ST_OK) begin
      r.op_is_get          = cmd_get;
      r.target_is_velocity = cmd_vel;
      r.dir_0              = cmd_dirs[0];
      r.dir_1              = cmd_dirs[1];
      r.dir_2              = cmd_dirs[2];
      r.dir_3              = cmd_dirs[3];
      r.dir_count          = cmd_ndirs;
      if (!cmd_get) begin
        r.value_0 = cmd_words[0];
        r.value_1 = cmd_words[1];
      end
    end
    pending_results.push_back(r);
    reset_cmd();
  endfunction

  function automatic void decode_char(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] u;
    logic [DIR_W-1:0]  d;
    int                h;
    u = upcase(c);
    d = dir_code(c);
    if (c == CH_NUL) begin
      case (cmd_phase)
        GET_DIRS, AWAIT_NUL, IGNORE_REST: finish_cmd(ST_OK);
        SKIP_TO_NUL: finish_cmd(cmd_err);
        SET_DIRS: finish_cmd(cmd_ndirs >= MAX_MOTOR_DIRECTIONS ? ST_NODASH : ST_BAD);
        default: finish_cmd(ST_BAD);
      endcase
      return;
    end
    case (cmd_phase)
      AWAIT_TYPE: begin
        if (u == CH_S || u == CH_G) begin
          cmd_get   = (u == CH_G);
          cmd_phase = AWAIT_TARGET;
        end else fail_cmd(ST_BAD);
      end
      AWAIT_TARGET: begin
        if (u == CH_S) begin
          cmd_vel = 1'b0;
          if (cmd_get) cmd_phase = GET_DIRS;
          else fail_cmd(ST_BAD);
        end else if (u == CH_V) begin
          cmd_vel   = 1'b1;
          cmd_phase = cmd_get ? GET_DIRS : SET_DIRS;
        end else fail_cmd(ST_BAD);
      end
      GET_DIRS: begin
        if (cmd_vel && d != DIR_RIGHT && d != DIR_LEFT) d = DIR_NONE;
        if (d == DIR_NONE) fail_cmd(ST_BAD);
        else begin
          push_dir(d);
          if (cmd_ndirs >= (cmd_vel ? MAX_MOTOR_DIRECTIONS : MAX_SENSOR_DIRECTIONS))
            cmd_phase = IGNORE_REST;
        end
      end
      SET_DIRS: begin
        if (c == CH_DASH) begin
          hex_pos   = '0;
          cmd_phase = (cmd_ndirs == 0) ? AWAIT_NUL : HEX_DIGITS;
        end else if (cmd_ndirs >= MAX_MOTOR_DIRECTIONS) fail_cmd(ST_NODASH);
        else if (d != DIR_RIGHT && d != DIR_LEFT) fail_cmd(ST_BAD);
        else push_dir(d);
      end
      HEX_DIGITS: begin
        if (c >= 8'h30 && c <= 8'h39) h = int'(c) - 'h30;
        else if (u >= 8'h41 && u <= 8'h46) h = int'(u) - 'h41 + 10;
        else h = -1;
        if (h < 0) fail_cmd(ST_BAD);
        else begin
          cmd_words[hex_pos[2]] = {cmd_words[hex_pos[2]][VALUE_W-5:0], 4'(h)};
          hex_pos = hex_pos + 1'b1;
          if (hex_pos >= 4 * cmd_ndirs || hex_pos >= 8) cmd_phase = AWAIT_NUL;
        end
      end
      AWAIT_NUL: fail_cmd(ST_BAD);
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst) begin
      if (s_valid && s_axis_tready) decode_char(s_data);
      if (m_axis_tvalid && m_ready) begin
        got = result_t'(m_axis_tdata[RESULT_W-1:0]);
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, got.status);
          check_field("op_is_get", want.op_is_get, got.op_is_get);
          check_field("target_is_velocity", want.target_is_velocity, got.target_is_velocity);
          check_field("dir_0", want.dir_0, got.dir_0);
          check_field("dir_1", want.dir_1, got.dir_1);
          check_field("dir_2", want.dir_2, got.dir_2);
          check_field("dir_3", want.dir_3, got.dir_3);
          check_field("dir_count", want.dir_count, got.dir_count);
          check_field("value_0", want.value_0, got.value_0);
          check_field("value_1", want.value_1, got.value_1);
          check_field("pad", 0, m_axis_tdata[OUT_W-1:RESULT_W]);
        end
      end
    end
  end

  always @(posedge clk) begin
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned rx_tick;
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: m_ready <= ((rx_tick % 11) < 7);
        default: m_ready <= 1'b1;
      endcase
    end
    rx_tick++;
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) idle = 0;
      else idle++;
    end
    $display("ascii_motion_command_parser_unit: mismatch");
    $finish;
  end

  // Caller sits at a rising edge; returns at the edge that accepts the item.
  task automatic send_char(logic [CHAR_W-1:0] c);
    int unsigned gap;
    if (tx_idle_en && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_valid <= 1'b1;
    s_data  <= c;
    do @(posedge clk); while (!s_axis_tready);
    chars_sent++;
  endtask

  task automatic send_cmd_buf();
    foreach (cmd_buf[k]) send_char(cmd_buf[k]);
    send_char(CH_NUL);
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send_char(s[k]);
    send_char(CH_NUL);
  endtask

  function automatic logic [CHAR_W-1:0] rand_case(logic [CHAR_W-1:0] c);
    if (c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1) == 1) return c | 8'h20;
    return c;
  endfunction

  task automatic make_random_cmd();
    int unsigned pick;
    int unsigned kind;
    int unsigned n;
    int unsigned pos;
    int unsigned style;
    int unsigned v;
    logic [CHAR_W-1:0] hx;
    cmd_buf.delete();
    pick = $urandom_range(0, 99);
    if (pick >= 92) begin
      n = $urandom_range(0, 6);
      repeat (n) cmd_buf.push_back(8'($urandom_range(1, 255)));
      return;
    end
    kind = $urandom_range(0, 9);
    cmd_buf.push_back(rand_case(kind < 5 ? CH_G : CH_S));
    cmd_buf.push_back(rand_case((kind < 3 || kind == 9) ? CH_S : CH_V));
    n = (kind < 3) ? $urandom_range(0, 4) : $urandom_range(0, 2);
    repeat (n) cmd_buf.push_back(rand_case(DIR_LETTERS[$urandom_range(0, kind < 3 ? 3 : 1)]));
    if (kind < 5 && n == (kind < 3 ? 4 : 2) && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) cmd_buf.push_back(8'($urandom_range(1, 255)));
    if (kind >= 5 && kind < 9) begin
      cmd_buf.push_back(CH_DASH);
      style = $urandom_range(0, 7);
      repeat (4 * n) begin
        v  = (style == 0) ? 15 : (style == 1) ? 0 : $urandom_range(0, 15);
        hx = (v < 10) ? 8'(8'h30 + v) : 8'(8'h41 + v - 10);
        cmd_buf.push_back(rand_case(hx));
      end
    end
    // break a share of the well-formed commands
    if (pick >= 75) begin
      pos = $urandom_range(0, cmd_buf.size() - 1);
      case ($urandom_range(0, 2))
        0: while (cmd_buf.size() > pos) void'(cmd_buf.pop_back());
        1: cmd_buf[pos] = 8'($urandom_range(1, 255));
        default: cmd_buf.insert(pos, 8'($urandom_range(1, 255)));
      endcase
    end
  endtask

  task automatic test_directed_commands();
    tx_idle_en = 1'b0;
    rx_mode    = RX_ALWAYS;
    send_text("");
    send_text("G");
    send_text("SV");
    send_text("SS");
    send_text("GSRLFB");
    send_text("gsrlfbq");
    send_text("GSB");
    send_text("GV");
    send_text("GVLR");
    send_text("gvrlx");
    send_text("GVF");
    send_text("SVRL-FFFF0000");
    send_text("svrl-0000ffff");
    send_text("sVr-aBcD");
    send_text("SV-");
    send_text("SV-1");
    send_text("SVR");
    send_text("SVRL");
    send_text("SVRLx");
    send_text("SVR-12G4");
    send_text("SVR-1234X");
    send_text("Q");
    cmd_buf = '{8'hFF, 8'h80, 8'h7F};
    send_cmd_buf();
  endtask

  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    rx_mode    = RX_ALWAYS;
    hold_seq++;
    repeat (6) send_text("GV");
  endtask

  task automatic test_random_commands();
    int unsigned base;
    base = chars_sent;
    for (int unsigned stage = 0; stage < 4; stage++) begin
      tx_idle_en = stage[0];
      rx_mode    = (stage == 2) ? RX_RANDOM : (stage == 3) ? RX_PATTERN : RX_ALWAYS;
      if (stage == 3) hold_seq++;
      while (chars_sent < base + (stage + 1) * RANDOM_CHARS / 4) begin
        make_random_cmd();
        send_cmd_buf();
      end
    end
  endtask

  initial begin
    reset_cmd();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_commands();
    test_output_backpressure();
    test_random_commands();
    s_valid <= 1'b0;
    rx_mode = RX_ALWAYS;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("ascii_motion_command_parser_unit: match");
    else $display("ascii_motion_command_parser_unit: mismatch");
    $finish;
  end

endmodule
